// ===== hw/rtl/sbc_pkg.sv =====
`default_nettype none

package sbc_pkg;

  localparam int SLOTS    = 10;
  localparam int CODE_W   = 6;
  localparam int ACC_W    = SLOTS * CODE_W;
  localparam int SLOT_W   = 4;
  localparam int WORD_W   = 64;
  localparam int CHAR_W   = 8;

  localparam logic [CODE_W-1:0] CODE_ZERO       = 6'h24;
  localparam logic [CODE_W-1:0] CODE_UNDERSCORE = 6'h25;
  localparam logic [CODE_W-1:0] CODE_INVALID    = 6'h26;
  localparam logic [CODE_W-1:0] CODE_STAR       = 6'h27;
  localparam logic [CHAR_W-1:0] CHAR_NACK       = 8'h15;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;
  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_CHAR   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_DECODE
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              bad;
  } enc_t;

  typedef struct packed {
    logic done_now;
    logic full;
  } pack_stat_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              inv;
    logic              stop;
  } unpk_stat_t;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] word;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              error;
  } result_t;

  function automatic enc_t encode_byte(input logic [CHAR_W-1:0] b);
    enc_t r;
    r.bad  = 1'b0;
    r.code = '0;
    case (b) inside
      [8'h41:8'h5A]: r.code = CODE_W'(b - 8'h37);
      [8'h61:8'h7A]: r.code = CODE_W'(b - 8'h57);
      [8'h31:8'h39]: r.code = CODE_W'(b - 8'h30);
      8'h30:         r.code = CODE_ZERO;
      8'h5F:         r.code = CODE_UNDERSCORE;
      8'h2A:         r.code = CODE_STAR;
      8'h00:         r.code = '0;
      default:       r.bad  = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] decode_code(input logic [CODE_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = '0;
    case (c) inside
      [6'd10:6'd35]:   r = CHAR_W'(c) + 8'h57;
      [6'd1:6'd9]:     r = CHAR_W'(c) + 8'h30;
      CODE_ZERO:       r = 8'h30;
      CODE_UNDERSCORE: r = 8'h5F;
      CODE_INVALID:    r = CHAR_NACK;
      CODE_STAR:       r = 8'h2A;
      default:         r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sbc_in_if.sv =====
`default_nettype none

interface sbc_in_if import sbc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAR_W-1:0] char_in;
  logic [WORD_W-1:0] word_in;

  modport source (output valid, mode, char_in, word_in, input ready);
  modport sink   (input valid, mode, char_in, word_in, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sbc_out_if.sv =====
`default_nettype none

interface sbc_out_if import sbc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [WORD_W-1:0] word_out;
  logic [CHAR_W-1:0] char_out;
  logic              last;
  logic              error;

  modport source (output valid, kind, word_out, char_out, last, error, input ready);
  modport sink   (input valid, kind, word_out, char_out, last, error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sbc_packer.sv =====
`default_nettype none

// codes enter at the top and shift down one slot per step
module sbc_packer import sbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic              shift,
  input  wire logic              clear,
  input  wire logic [CHAR_W-1:0] char_in,
  output logic [ACC_W-1:0]       acc,
  output logic                   err,
  output pack_stat_t             stat
);

  logic [SLOT_W-1:0] slot;
  enc_t              enc;

  always_comb begin
    enc           = encode_byte(char_in);
    stat.done_now = (enc.code == '0) || (slot == SLOT_W'(SLOTS - 1));
    stat.full     = (slot == SLOT_W'(SLOTS));
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc  <= '0;
      slot <= '0;
      err  <= 1'b0;
    end else if (take) begin
      acc  <= {enc.code, acc[ACC_W-1:CODE_W]};
      slot <= slot + 1'b1;
      err  <= err | enc.bad;
    end else if (shift) begin
      acc  <= {{CODE_W{1'b0}}, acc[ACC_W-1:CODE_W]};
      slot <= slot + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbc_unpacker.sv =====
`default_nettype none

module sbc_unpacker import sbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic              step,
  input  wire logic [WORD_W-1:0] word_in,
  output unpk_stat_t             stat
);

  logic [ACC_W-1:0]  sr;
  logic [SLOT_W-1:0] idx;

  always_comb begin
    stat.ch   = decode_code(sr[CODE_W-1:0]);
    stat.inv  = (sr[CODE_W-1:0] == CODE_INVALID);
    stat.stop = (stat.ch == '0) || stat.inv || (idx == SLOT_W'(SLOTS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= '0;
    end else if (step) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sr <= word_in[ACC_W-1:0];
    end else if (step) begin
      sr <= {{CODE_W{1'b0}}, sr[ACC_W-1:CODE_W]};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/six_bit_char_pack_unpack_top.sv =====
// Encode: a byte that does not finish a word is taken in IDLE; such bytes go back to back.
// A byte that finishes a word (zero code or tenth slot) starts FLUSH, which shifts the
// packer one slot per cycle to the tenth slot, then loads the word when output is free.
// Decode: up to 10 characters from the unpacker, one per cycle while the output is free.
// Results sit in an output register; input is taken in IDLE while it waits.
// Synchronous reset empties the accumulator and the output register, state IDLE.
`default_nettype none

module six_bit_char_pack_unpack_top import sbc_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  sbc_in_if.sink   req,
  sbc_out_if.source rsp
);

  state_t     state, state_next;
  logic       accept, out_free;
  logic       pk_take, pk_shift, pk_clear;
  logic       up_load, up_step, load_out;
  logic [ACC_W-1:0] acc;
  logic       pk_err;
  pack_stat_t pk_stat;
  unpk_stat_t up_stat;
  result_t    res, res_next;
  logic       out_valid;

  sbc_packer u_pack (
    .clk, .rst,
    .take    (pk_take),
    .shift   (pk_shift),
    .clear   (pk_clear),
    .char_in (req.char_in),
    .acc     (acc),
    .err     (pk_err),
    .stat    (pk_stat)
  );

  sbc_unpacker u_unpack (
    .clk, .rst,
    .load    (up_load),
    .step    (up_step),
    .word_in (req.word_in),
    .stat    (up_stat)
  );

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req.mode == MODE_ENCODE && pk_stat.done_now) state_next = ST_FLUSH;
        else if (accept && req.mode == MODE_DECODE) state_next = ST_DECODE;
      end
      ST_FLUSH: begin
        if (pk_stat.full && out_free) state_next = ST_IDLE;
      end
      ST_DECODE: begin
        if (out_free && up_stat.stop) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    pk_take   = 1'b0;
    pk_shift  = 1'b0;
    pk_clear  = 1'b0;
    up_load   = 1'b0;
    up_step   = 1'b0;
    load_out  = 1'b0;
    res_next  = res;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        pk_take   = accept && req.mode == MODE_ENCODE;
        up_load   = accept && req.mode == MODE_DECODE;
      end
      ST_FLUSH: begin
        pk_shift = !pk_stat.full;
        if (pk_stat.full && out_free) begin
          load_out       = 1'b1;
          pk_clear       = 1'b1;
          res_next.kind  = KIND_WORD;
          res_next.word  = {1'b1, {(WORD_W-1-ACC_W){1'b0}}, acc};
          res_next.ch    = '0;
          res_next.last  = 1'b0;
          res_next.error = pk_err;
        end
      end
      ST_DECODE: begin
        if (out_free) begin
          load_out       = 1'b1;
          up_step        = 1'b1;
          res_next.kind  = KIND_CHAR;
          res_next.word  = '0;
          res_next.ch    = up_stat.ch;
          res_next.last  = up_stat.stop;
          res_next.error = up_stat.inv;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) res <= res_next;
  end

  assign rsp.valid    = out_valid;
  assign rsp.kind     = res.kind;
  assign rsp.word_out = res.word;
  assign rsp.char_out = res.ch;
  assign rsp.last     = res.last;
  assign rsp.error    = res.error;

  a_word_marked: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.kind == KIND_WORD |-> rsp.word_out[WORD_W-1])
    else $error("packed word without marker");

  a_char_no_word: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.kind == KIND_CHAR |-> rsp.word_out == '0)
    else $error("character beat carries word bits");

  a_decode_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.mode == MODE_DECODE |=> !req.ready)
    else $error("input taken during decode");

endmodule

`default_nettype wire

// ===== bench/six_bit_char_pack_unpack_top_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none

module six_bit_char_pack_unpack_top_tb;
  import sbc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;

  sbc_in_if  req_if ();
  sbc_out_if rsp_if ();

  six_bit_char_pack_unpack_top dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  logic [ACC_W-1:0]  pack_acc;
  logic [SLOT_W-1:0] slot_pos;
  logic              pack_err;
  result_t           expected_results[$];

  int fail_count;
  int cycle_count = 0;
  int stall_left = 0;
  bit idle_on;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [CODE_W-1:0] char_to_code(input logic [CHAR_W-1:0] b,
                                                     output logic bad);
    logic [CHAR_W-1:0] t;
    bad = 1'b0;
    t = '0;
    if (b >= "A" && b <= "Z") begin
      t = b - 8'h41 + 8'd10;
    end else if (b >= "a" && b <= "z") begin
      t = b - 8'h61 + 8'd10;
    end else if (b >= "1" && b <= "9") begin
      t = b - 8'h30;
    end else if (b == "0") begin
      t = {2'b00, CODE_ZERO};
    end else if (b == "_") begin
      t = {2'b00, CODE_UNDERSCORE};
    end else if (b == "*") begin
      t = {2'b00, CODE_STAR};
    end else if (b != 8'h00) begin
      bad = 1'b1;
    end
    return t[CODE_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] code_to_char(input logic [CODE_W-1:0] c);
    logic [CHAR_W-1:0] cc;
    cc = {2'b00, c};
    if (c >= 6'd10 && c <= 6'd35) return cc - 8'd10 + 8'h61;
    if (c >= 6'd1 && c <= 6'd9) return cc + 8'h30;
    if (c == CODE_ZERO) return "0";
    if (c == CODE_UNDERSCORE) return "_";
    if (c == CODE_INVALID) return CHAR_NACK;
    if (c == CODE_STAR) return "*";
    return 8'h00;
  endfunction

  task automatic predict_pack(input logic [CHAR_W-1:0] b);
    logic [CODE_W-1:0] code;
    logic [ACC_W-1:0]  ext;
    logic              bad;
    logic              done;
    result_t           r;
    code = char_to_code(b, bad);
    if (slot_pos < SLOTS) begin
      ext = '0;
      ext[CODE_W-1:0] = code;
      pack_acc = pack_acc | (ext << (CODE_W * slot_pos));
      slot_pos = slot_pos + 1'b1;
      if (bad) pack_err = 1'b1;
      done = (code == '0) || (slot_pos >= SLOTS);
    end else begin
      done = 1'b1;
    end
    if (done) begin
      r.kind  = KIND_WORD;
      r.word  = {1'b1, {(WORD_W-ACC_W-1){1'b0}}, pack_acc};
      r.ch    = '0;
      r.last  = 1'b0;
      r.error = pack_err;
      expected_results.push_back(r);
      pack_acc = '0;
      slot_pos = '0;
      pack_err = 1'b0;
    end
  endtask

  task automatic predict_unpack(input logic [WORD_W-1:0] w);
    logic [CODE_W-1:0] code;
    logic              stopped;
    result_t           r;
    stopped = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!stopped) begin
        code    = w[CODE_W*i +: CODE_W];
        r.kind  = KIND_CHAR;
        r.word  = '0;
        r.ch    = code_to_char(code);
        r.error = (code == CODE_INVALID);
        r.last  = (r.ch == 8'h00) || r.error || (i == SLOTS - 1);
        expected_results.push_back(r);
        stopped = r.last;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic send_item(input logic m, input logic [CHAR_W-1:0] c,
                           input logic [WORD_W-1:0] w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.mode    <= m;
    req_if.char_in <= c;
    req_if.word_in <= w;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (m == MODE_ENCODE) predict_pack(c);
    else predict_unpack(w);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CHAR_W-1:0] rand_good_char();
    logic [CHAR_W-1:0] r;
    case ($urandom_range(0, 5))
      0: r = CHAR_W'(8'h41 + $urandom_range(0, 25));
      1: r = CHAR_W'(8'h61 + $urandom_range(0, 25));
      2: r = CHAR_W'(8'h31 + $urandom_range(0, 8));
      3: r = "0";
      4: r = "_";
      default: r = "*";
    endcase
    return r;
  endfunction

  task automatic test_encode_directed();
    logic [CHAR_W-1:0] phrase[10];
    phrase = '{"A", "Z", "a", "z", "1", "9", "0", "_", "*", "5"};
    foreach (phrase[i]) send_item(MODE_ENCODE, phrase[i], rand_word());
    send_item(MODE_ENCODE, "x", rand_word());
    send_item(MODE_ENCODE, 8'hFF, rand_word());
    send_item(MODE_ENCODE, 8'h00, rand_word());
    send_item(MODE_ENCODE, "/", '0);
    send_item(MODE_ENCODE, "q", '1);
    send_item(MODE_ENCODE, 8'h00, rand_word());
  endtask

  task automatic test_decode_directed();
    send_item(MODE_DECODE, 8'hFF, '0);
    send_item(MODE_DECODE, 8'h00, '1);
    send_item(MODE_DECODE, rand_good_char(),
              {4'h8, 6'd35, 6'd10, 6'd9, 6'd1, CODE_STAR, CODE_UNDERSCORE,
               CODE_ZERO, 6'd20, 6'd11, 6'd12});
    send_item(MODE_DECODE, 8'h00,
              {4'h7, 6'd5, 6'd5, 6'd5, 6'd5, 6'd5, 6'd5, CODE_INVALID, 6'd2,
               6'd3, 6'd4});
    send_item(MODE_DECODE, 8'h00,
              {4'hF, 6'd5, 6'd5, 6'd5, 6'd5, 6'd5, 6'd5, 6'd5, 6'd40,
               CODE_STAR, CODE_ZERO});
    send_item(MODE_DECODE, 8'h00,
              {4'h0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd63,
               CODE_UNDERSCORE, 6'd33});
    send_item(MODE_DECODE, 8'h00, {4'h5, {9{6'd17}}, CODE_INVALID});
  endtask

  task automatic send_random_items(input int count);
    int                sent;
    int                len;
    int                pick;
    logic [WORD_W-1:0] w;
    logic [CODE_W-1:0] c;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = $urandom_range(0, 10);
        for (int k = 0; k < len; k++) begin
          send_item(MODE_ENCODE, rand_good_char(), rand_word());
          sent++;
        end
        if (len < 10 && $urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 4) == 0)
            send_item(MODE_ENCODE, CHAR_W'($urandom_range(0, 255)), rand_word());
          else send_item(MODE_ENCODE, 8'h00, rand_word());
          sent++;
        end
      end else if (pick < 75) begin
        len = $urandom_range(0, 10);
        w = rand_word();
        for (int k = 0; k < SLOTS; k++) begin
          if (k < len) begin
            c = CODE_W'($urandom_range(1, 38));
            if (c == CODE_INVALID) c = CODE_STAR;
          end else if (k == len) begin
            case ($urandom_range(0, 3))
              0: c = '0;
              1: c = CODE_INVALID;
              default: c = CODE_W'($urandom_range(40, 63));
            endcase
          end else begin
            c = CODE_W'($urandom_range(0, 63));
          end
          w[CODE_W*k +: CODE_W] = c;
        end
        send_item(MODE_DECODE, CHAR_W'($urandom_range(0, 255)), w);
        sent++;
      end else if (pick < 90) begin
        send_item(MODE_ENCODE, CHAR_W'($urandom_range(0, 255)), rand_word());
        sent++;
      end else begin
        send_item(MODE_DECODE, CHAR_W'($urandom_range(0, 255)), rand_word());
        sent++;
      end
    end
  endtask

  task automatic test_random_mix();
    idle_on = 1'b1;
    send_random_items(400);
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    send_random_items(100);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 12);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", rsp_if.word_out, '0);
      end else begin
        want = expected_results.pop_front();
        if (rsp_if.kind !== want.kind)
          report_mismatch("kind", WORD_W'(rsp_if.kind), WORD_W'(want.kind));
        if (rsp_if.word_out !== want.word) report_mismatch("word_out", rsp_if.word_out, want.word);
        if (rsp_if.char_out !== want.ch)
          report_mismatch("char_out", WORD_W'(rsp_if.char_out), WORD_W'(want.ch));
        if (rsp_if.last !== want.last)
          report_mismatch("last", WORD_W'(rsp_if.last), WORD_W'(want.last));
        if (rsp_if.error !== want.error)
          report_mismatch("error", WORD_W'(rsp_if.error), WORD_W'(want.error));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    fail_count  = 0;
    idle_on     = 1'b0;
    pack_acc    = '0;
    slot_pos    = '0;
    pack_err    = 1'b0;
    rst            <= 1'b1;
    req_if.valid   <= 1'b0;
    req_if.mode    <= MODE_ENCODE;
    req_if.char_in <= '0;
    req_if.word_in <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_encode_directed();
    test_decode_directed();
    test_random_mix();
    test_full_rate();

    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/sbc_pkg.sv
hw/rtl/sbc_in_if.sv
hw/rtl/sbc_out_if.sv
hw/rtl/sbc_packer.sv
hw/rtl/sbc_unpacker.sv
hw/rtl/six_bit_char_pack_unpack_top.sv
bench/six_bit_char_pack_unpack_top_tb.sv
